>>> src/joystick_to_dual_motor_mixer_unit_defines.svh
// Assertion macros used by the mixer sequencer (jdmm_ctrl).
`ifndef JOYSTICK_TO_DUAL_MOTOR_MIXER_UNIT_DEFINES_SVH
`define JOYSTICK_TO_DUAL_MOTOR_MIXER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define JDMM_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define JDMM_ASSERT_NEXT(name, clk, rstn, cond, res) \
  name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (res)) \
    else $error("assertion failed");
`else
`define JDMM_ASSERT(name, clk, rstn, prop)
`define JDMM_ASSERT_NEXT(name, clk, rstn, cond, res)
`endif
`endif

>>> src/jdmm_pkg.sv
package jdmm_pkg;

  localparam int MaxDuty      = 1023;
  localparam int StartDuty    = 80;
  localparam int TurnSpeedCap = 800;

  // Divider operand widths.
  localparam int NumW = 27;
  localparam int DenW = 17;

  typedef struct packed {
    logic signed [15:0] y_min;
    logic signed [15:0] y_mid;
    logic signed [15:0] y_max;
    logic signed [15:0] x_min;
    logic signed [15:0] x_mid;
    logic signed [15:0] x_max;
    logic [14:0]        deadband;
    logic [2:0]         drive_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_Y_MIN      = 3'd0,
    REG_Y_MID      = 3'd1,
    REG_Y_MAX      = 3'd2,
    REG_X_MIN      = 3'd3,
    REG_X_MID      = 3'd4,
    REG_X_MAX      = 3'd5,
    REG_DEADBAND   = 3'd6,
    REG_DRIVE_MODE = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    MODE_CAR     = 2'd0,
    MODE_TANK    = 2'd1,
    MODE_TANK_V2 = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_X = 2'd0,
    OP_Y = 2'd1,
    OP_T = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] dir;
    logic [9:0] duty;
  } motor_t;

  typedef struct packed {
    logic load_in;
    logic setup;
    op_e  op;
    logic div_start;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic passthru;
    logic tank_v2;
    logic div_done;
    logic out_busy;
  } sts_t;

  // Direction and duty for one motor from a signed speed.
  function automatic motor_t drive(input logic signed [17:0] v);
    logic [17:0] m;
    motor_t      r;
    m = v[17] ? 18'(-v) : 18'(v);
    if (m > 18'(MaxDuty)) m = 18'(MaxDuty);
    r.dir  = DIR_STOP;
    r.duty = '0;
    if (m >= 18'(StartDuty) && v != 18'sd0) begin
      r.dir  = v[17] ? DIR_REV : DIR_FWD;
      r.duty = m[9:0];
    end
    return r;
  endfunction

endpackage

>>> src/jdmm_stick_if.sv
interface jdmm_stick_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] stick_y;
  logic signed [15:0] stick_x;
  modport source (output valid, stick_y, stick_x, input ready);
  modport sink (input valid, stick_y, stick_x, output ready);
endinterface

>>> src/jdmm_motor_if.sv
interface jdmm_motor_if;
  logic       valid;
  logic       ready;
  logic [1:0] left_dir;
  logic [9:0] left_duty;
  logic [1:0] right_dir;
  logic [9:0] right_duty;
  modport source (output valid, left_dir, left_duty, right_dir, right_duty, input ready);
  modport sink (input valid, left_dir, left_duty, right_dir, right_duty, output ready);
endinterface

>>> src/jdmm_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module jdmm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [jdmm_pkg::NumW-1:0]  num_i,
  input  logic [jdmm_pkg::DenW-1:0]  den_i,
  output logic [jdmm_pkg::NumW-1:0]  quo_o,
  output logic                       done_o
);

  localparam int NumW = jdmm_pkg::NumW;
  localparam int DenW = jdmm_pkg::DenW;

  logic [NumW-1:0] acc_q, acc_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [4:0]      cnt_q, cnt_d;
  logic [DenW:0]   rem_sh;
  logic [DenW+1:0] diff;

  always_comb begin
    rem_sh = {rem_q, acc_q[NumW-1]};
    diff   = {1'b0, rem_sh} - {2'b0, den_q};
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      acc_d = num_i;
      rem_d = '0;
      cnt_d = 5'(NumW);
    end else if (cnt_q != 5'd0) begin
      cnt_d = cnt_q - 5'd1;
      if (!diff[DenW+1]) begin
        rem_d = diff[DenW-1:0];
        acc_d = {acc_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DenW-1:0];
        acc_d = {acc_q[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quo_o  = acc_q;
  assign done_o = (cnt_q == 5'd0);

endmodule

>>> src/jdmm_dp.sv
// Mixer datapath: axis map operands, multiplier, divider, mode logic and
// the output register.
module jdmm_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jdmm_pkg::cfg_t      cfg_i,
  input  jdmm_pkg::cmd_t      cmd_i,
  output jdmm_pkg::sts_t      sts_o,
  input  logic signed [15:0]  in_y_i,
  input  logic signed [15:0]  in_x_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output jdmm_pkg::motor_t    out_left_o,
  output jdmm_pkg::motor_t    out_right_o
);

  localparam logic signed [10:0] StartS = 11'(jdmm_pkg::StartDuty);
  localparam logic signed [10:0] CapS   = 11'(jdmm_pkg::TurnSpeedCap);
  localparam logic signed [11:0] Max12  = 12'(jdmm_pkg::MaxDuty);
  localparam logic signed [11:0] Start12 = 12'(jdmm_pkg::StartDuty);
  localparam logic signed [11:0] Span12 = 12'(jdmm_pkg::MaxDuty - jdmm_pkg::StartDuty);
  localparam logic signed [13:0] Max14  = 14'(jdmm_pkg::MaxDuty);
  localparam logic signed [17:0] Start18 = 18'(jdmm_pkg::StartDuty);

  function automatic logic signed [15:0] clampv(input logic signed [15:0] v,
                                               input logic signed [15:0] lo,
                                               input logic signed [15:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  logic signed [15:0] y_q, x_q, yc, xc;
  logic signed [18:0] a_q, den_q;
  logic signed [11:0] k_q, ol_q;
  logic               zero_q, neg_q;
  logic signed [10:0] lx_q, ly_q, lt_q, run_q, held_q;
  logic               out_valid_q;
  jdmm_pkg::motor_t   out_l_q, out_r_q;

  logic [1:0]         mode;
  logic               rev, tank_v2, passthru;
  logic signed [10:0] hn;

  // Operand setup.
  logic signed [15:0] sv, slo, smid, shi;
  logic signed [17:0] up, dn, v18, il, ih;
  logic signed [18:0] a_d, den_d;
  logic signed [11:0] k_d, ol_d;
  logic               live;

  // Multiply and divide.
  logic signed [30:0]               prod;
  logic [30:0]                      prod_mag;
  logic [18:0]                      den_mag;
  logic [jdmm_pkg::NumW-1:0]        quo;
  logic                             div_done;

  // Final map value.
  logic [11:0]        qs;
  logic signed [13:0] qv, rv;
  logic signed [10:0] res;

  // Output decision.
  logic signed [17:0] l, r, lr, rs, h, t;
  logic signed [10:0] run_d, held_d, tc;
  logic               produce;

  assign mode     = cfg_i.drive_mode[2:1];
  assign rev      = cfg_i.drive_mode[0];
  assign tank_v2  = (mode == jdmm_pkg::MODE_TANK_V2);
  assign passthru = (cfg_i.y_min == 16'sd0) && (cfg_i.y_max == 16'sd0) &&
                    (cfg_i.x_min == 16'sd0) && (cfg_i.x_max == 16'sd0);

  assign yc = clampv(y_q, cfg_i.y_min, cfg_i.y_max);
  assign xc = clampv(x_q, cfg_i.x_min, cfg_i.x_max);

  // Held speed as tank_v2 leaves it after this sample.
  always_comb begin
    hn = held_q;
    if (lx_q != 11'sd0 && ly_q != 11'sd0) begin
      if (held_q == 11'sd0) hn = ly_q;
    end else if (lx_q == 11'sd0 && ly_q == 11'sd0) begin
      hn = 11'sd0;
    end
  end

  always_comb begin
    if (cmd_i.op == jdmm_pkg::OP_X) begin
      sv = xc; slo = cfg_i.x_min; smid = cfg_i.x_mid; shi = cfg_i.x_max;
    end else begin
      sv = yc; slo = cfg_i.y_min; smid = cfg_i.y_mid; shi = cfg_i.y_max;
    end
    v18 = 18'(sv);
    up  = 18'(smid) + 18'(signed'({1'b0, cfg_i.deadband}));
    dn  = 18'(smid) - 18'(signed'({1'b0, cfg_i.deadband}));
    il  = up;
    ih  = 18'(shi);
    k_d = Span12;
    ol_d = Start12;
    live = 1'b1;
    if (cmd_i.op == jdmm_pkg::OP_T) begin
      il = 18'(cfg_i.y_min);
      ih = 18'(cfg_i.y_max);
      if (hn > 11'sd0) begin
        ol_d = 12'sd0;
        k_d  = Max12;
      end else begin
        ol_d = Max12;
        k_d  = -Max12;
      end
    end else if (v18 > up) begin
      il = up;
      ih = 18'(shi);
    end else if (v18 < dn) begin
      il   = dn;
      ih   = 18'(slo);
      ol_d = -Start12;
      k_d  = -Span12;
    end else begin
      live = 1'b0;
    end
    a_d   = 19'(v18) - 19'(il);
    den_d = 19'(ih) - 19'(il);
  end

  assign prod     = 31'(a_q) * 31'(k_q);
  assign prod_mag = prod[30] ? 31'(-prod) : 31'(prod);
  assign den_mag  = den_q[18] ? 19'(-den_q) : 19'(den_q);

  jdmm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_mag[jdmm_pkg::NumW-1:0]),
    .den_i   (den_mag[jdmm_pkg::DenW-1:0]),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  // Truncated quotient with sign, offset and saturation to the duty range.
  always_comb begin
    qs  = (|quo[jdmm_pkg::NumW-1:12]) ? 12'hFFF : quo[11:0];
    qv  = neg_q ? -14'(signed'({1'b0, qs})) : 14'(signed'({1'b0, qs}));
    rv  = qv + 14'(ol_q);
    if (rv > Max14) rv = Max14;
    if (rv < -Max14) rv = -Max14;
    res = zero_q ? 11'sd0 : 11'(rv);
  end

  always_comb begin
    lr      = 18'(lx_q);
    rs      = 18'(ly_q);
    h       = 18'(hn);
    t       = 18'sd0;
    tc      = 11'sd0;
    l       = 18'sd0;
    r       = 18'sd0;
    run_d   = run_q;
    held_d  = held_q;
    produce = 1'b1;
    if (passthru) begin
      l = 18'(y_q);
      r = 18'(x_q);
    end else if (tank_v2) begin
      run_d  = ly_q;
      held_d = hn;
      if (hn == 11'sd0) begin
        if (rs == 18'sd0 && lr != 18'sd0) begin
          l = rev ? lr : -lr;
          r = rev ? -lr : lr;
        end else if (rs != 18'sd0 && lr == 18'sd0) begin
          l = rs;
          r = rs;
        end
      end else if (lr == 18'sd0) begin
        produce = 1'b0;
      end else begin
        if (hn > 11'sd0) begin
          tc = (lt_q < 11'sd0) ? 11'sd0 : ((lt_q > hn) ? hn : lt_q);
          t  = 18'(tc);
        end else begin
          tc = (lt_q < 11'sd0) ? 11'sd0 : ((lt_q > -hn) ? -hn : lt_q);
          t  = -18'(tc);
        end
        l = (lr > 18'sd0) ? h : t;
        r = (lr > 18'sd0) ? t : h;
      end
    end else begin
      if (lx_q == 11'sd0) begin
        run_d = ly_q;
      end else if (run_q > 11'sd0) begin
        run_d = (run_q < StartS) ? StartS : ((run_q > CapS) ? CapS : run_q);
      end else if (run_q < 11'sd0) begin
        run_d = (run_q < -CapS) ? -CapS : ((run_q > -StartS) ? -StartS : run_q);
      end else begin
        run_d = ly_q;
      end
      rs = 18'(run_d);
      if (mode != jdmm_pkg::MODE_TANK) begin
        l = rs;
        r = lr;
      end else if (rs == 18'sd0 && lr != 18'sd0) begin
        l = rev ? lr : -lr;
        r = rev ? -lr : lr;
      end else if (lr == 18'sd0) begin
        l = rs;
        r = rs;
      end else if (rs > 18'sd0) begin
        l = (lr >= 18'sd0) ? Start18 + lr : Start18;
        r = (lr >= 18'sd0) ? Start18 : Start18 - lr;
      end else begin
        l = (lr >= 18'sd0) ? -Start18 - lr : -Start18;
        r = (lr >= 18'sd0) ? -Start18 : -Start18 + lr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      y_q <= in_y_i;
      x_q <= in_x_i;
    end
    if (cmd_i.setup) begin
      a_q    <= a_d;
      den_q  <= den_d;
      k_q    <= k_d;
      ol_q   <= ol_d;
      zero_q <= !live || (den_d == 19'sd0);
    end
    if (cmd_i.div_start) begin
      neg_q <= prod[30] ^ den_q[18];
    end
    if (cmd_i.fin) begin
      case (cmd_i.op)
        jdmm_pkg::OP_X: lx_q <= res;
        jdmm_pkg::OP_Y: ly_q <= res;
        jdmm_pkg::OP_T: lt_q <= res;
        default:        lt_q <= res;
      endcase
    end
    if (cmd_i.out_load && produce) begin
      out_l_q <= jdmm_pkg::drive(l);
      out_r_q <= jdmm_pkg::drive(r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.out_load) begin
        run_q  <= run_d;
        held_q <= held_d;
      end
      if (cmd_i.out_load && produce) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.passthru = passthru;
  assign sts_o.tank_v2  = tank_v2;
  assign sts_o.div_done = div_done;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;

endmodule

>>> src/jdmm_ctrl.sv
`include "joystick_to_dual_motor_mixer_unit_defines.svh"

// Sequencer: runs the steering map, the forward map and, in tank_v2, the
// turn map through the shared multiplier and divider; in passthrough it skips the maps.
module jdmm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jdmm_pkg::sts_t sts_i,
  output jdmm_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_MUL   = 6'b000100,
    S_DIV   = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  jdmm_pkg::op_e op_q, op_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          op_d    = jdmm_pkg::OP_X;
          state_d = sts_i.passthru ? S_OUT : S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        case (op_q)
          jdmm_pkg::OP_X: begin
            op_d    = jdmm_pkg::OP_Y;
            state_d = S_SETUP;
          end
          jdmm_pkg::OP_Y: begin
            op_d    = jdmm_pkg::OP_T;
            state_d = sts_i.tank_v2 ? S_SETUP : S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= jdmm_pkg::OP_X;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  `JDMM_ASSERT(a_state_onehot, clk_i, rst_ni, $onehot(state_q))
  `JDMM_ASSERT_NEXT(a_div_busy, clk_i, rst_ni, cmd_o.div_start, !sts_i.div_done)
  `JDMM_ASSERT_NEXT(a_out_done, clk_i, rst_ni, state_q == S_OUT && !sts_i.out_busy, state_q == S_IDLE)

endmodule

>>> src/joystick_to_dual_motor_mixer_unit.sv
// Joystick to dual motor mixer. Each joystick transfer (stick_y, stick_x)
// yields at most one motor transfer with a direction and a 10-bit PWM duty
// for the left and right motor. With y_min, y_max, x_min and x_max all zero
// the sticks drive the motors directly. Otherwise each axis map runs through
// one multiplier and a shared restoring divider that produces one quotient
// bit per cycle: car and tank mode run the steering map then the forward
// map, and tank_v2 adds the turn map. A finished result sits in an output
// register, and the next joystick transfer is taken while it waits. In
// tank_v2 with a held speed and centred steering no motor transfer is
// produced. Configuration is written over the APB port at byte address
// 4*index and must only be written while the block is idle.
module joystick_to_dual_motor_mixer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  jdmm_stick_if.sink   stick_i,
  jdmm_motor_if.source motor_o
);

  jdmm_pkg::cfg_t   cfg_q;
  jdmm_pkg::cmd_t   cmd;
  jdmm_pkg::sts_t   sts;
  jdmm_pkg::motor_t left, right;
  jdmm_pkg::reg_e   reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = jdmm_pkg::reg_e'(paddr[4:2]);

  // Register file, written in the APB access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        jdmm_pkg::REG_Y_MIN:      cfg_q.y_min      <= pwdata[15:0];
        jdmm_pkg::REG_Y_MID:      cfg_q.y_mid      <= pwdata[15:0];
        jdmm_pkg::REG_Y_MAX:      cfg_q.y_max      <= pwdata[15:0];
        jdmm_pkg::REG_X_MIN:      cfg_q.x_min      <= pwdata[15:0];
        jdmm_pkg::REG_X_MID:      cfg_q.x_mid      <= pwdata[15:0];
        jdmm_pkg::REG_X_MAX:      cfg_q.x_max      <= pwdata[15:0];
        jdmm_pkg::REG_DEADBAND:   cfg_q.deadband   <= pwdata[14:0];
        jdmm_pkg::REG_DRIVE_MODE: cfg_q.drive_mode <= pwdata[2:0];
        default:                  cfg_q.drive_mode <= pwdata[2:0];
      endcase
    end
  end

  // Read-back; the signed limits come back sign-extended.
  always_comb begin
    case (reg_sel)
      jdmm_pkg::REG_Y_MIN:      prdata = 32'(cfg_q.y_min);
      jdmm_pkg::REG_Y_MID:      prdata = 32'(cfg_q.y_mid);
      jdmm_pkg::REG_Y_MAX:      prdata = 32'(cfg_q.y_max);
      jdmm_pkg::REG_X_MIN:      prdata = 32'(cfg_q.x_min);
      jdmm_pkg::REG_X_MID:      prdata = 32'(cfg_q.x_mid);
      jdmm_pkg::REG_X_MAX:      prdata = 32'(cfg_q.x_max);
      jdmm_pkg::REG_DEADBAND:   prdata = {17'b0, cfg_q.deadband};
      jdmm_pkg::REG_DRIVE_MODE: prdata = {29'b0, cfg_q.drive_mode};
      default:                  prdata = '0;
    endcase
  end

  jdmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (stick_i.valid),
    .in_ready_o (stick_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jdmm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_y_i      (stick_i.stick_y),
    .in_x_i      (stick_i.stick_x),
    .out_ready_i (motor_o.ready),
    .out_valid_o (motor_o.valid),
    .out_left_o  (left),
    .out_right_o (right)
  );

  assign motor_o.left_dir   = left.dir;
  assign motor_o.left_duty  = left.duty;
  assign motor_o.right_dir  = right.dir;
  assign motor_o.right_duty = right.duty;

endmodule
